[hw/rtl/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg
// shared widths, register codes, reset values and types of the pwm duty
// capture block
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int STAMP_W    = 32;
    localparam int CH_PORT_W  = 2;
    localparam int DUTY_W     = 14;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0] FULL_SCALE = 14'd10000;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 14'h3fff;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HIGH      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_FILTER_ON = 4'd3;

    localparam logic [DUTY_W-1:0] RST_DUTY_LOW       = 14'd8847;
    localparam logic [DUTY_W-1:0] RST_DUTY_HIGH      = 14'd9330;
    localparam logic [DUTY_W-1:0] RST_STEP_LIMIT     = 14'd200;
    localparam logic              RST_STEP_FILTER_ON = 1'b1;

    // job queue between capture front and divide back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [1:0] {
        PH_WAIT_RISE  = 2'd0,
        PH_WAIT_FALL  = 2'd1,
        PH_WAIT_RISE2 = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        B_IDLE = 3'd0,
        B_MUL  = 3'd1,
        B_SAT  = 3'd2,
        B_DIV  = 3'd3,
        B_FILT = 3'd4
    } t_bstate;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_low;
        logic [DUTY_W-1:0] duty_high;
        logic [DUTY_W-1:0] step_limit;
        logic              step_filter_on;
    } t_cfg;

    typedef struct packed {
        logic [CH_PORT_W-1:0] ch;
        logic [STAMP_W-1:0]   period;
        logic [STAMP_W-1:0]   hi;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hw/rtl/pwm_duty_capture_core.sv]
// ----------------------------------------------------------------------------
// pwm_duty_capture_core
// four-channel pwm input capture with duty window and step filter
// ----------------------------------------------------------------------------
// edge beats enter through i_push / o_full: channel, polarity and the counter
// stamp latched at the edge. each channel waits rise, fall, rise; the second
// rise completes a measurement and queues a job for the divide back end.
// an edge beat is taken every cycle while the two-entry job queue has room;
// only completing edges occupy the queue.
// results leave through o_empty / i_pop with period, high time, duty and the
// held flag. a job goes from queue to result register in steps: a load,
// a multiply, a saturation check, 14 restoring-divide steps (one quotient
// bit per cycle) and a filter step. the back end takes no new job until
// the last one is in the result register; the shared divider sets its pace.
// while the receiver stalls, the finished result waits in the output
// register, the back end holds in its filter step and the queue fills; then
// o_full rises. configuration writes are always taken (o_cfg_ready high).
// reset re-arms every channel, clears the last duties and restores defaults.
// ----------------------------------------------------------------------------
module pwm_duty_capture_core
    import pdc_pkg::*;
#(
    parameter int NUM_CHANNELS  = 4,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [CH_PORT_W-1:0]  i_channel,
    input  logic                  i_edge_rising,
    input  logic [STAMP_W-1:0]    i_stamp,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [CH_PORT_W-1:0]  o_out_channel,
    output logic [STAMP_W-1:0]    o_period_ticks,
    output logic [STAMP_W-1:0]    o_high_ticks,
    output logic [DUTY_W-1:0]     o_duty,
    output logic                  o_held,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_cfg      n_cfg;
    t_job      w_front_job;
    t_job      w_back_job;
    logic      w_push;
    logic      w_job_pop;
    t_q_status w_q_status;
    logic      w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_full      = w_q_status.full;
    assign w_accept    = i_push && !w_q_status.full;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DUTY_LOW:       n_cfg.duty_low       = i_cfg_data[DUTY_W-1:0];
                CFG_DUTY_HIGH:      n_cfg.duty_high      = i_cfg_data[DUTY_W-1:0];
                CFG_STEP_LIMIT:     n_cfg.step_limit     = i_cfg_data[DUTY_W-1:0];
                CFG_STEP_FILTER_ON: n_cfg.step_filter_on = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_low       <= RST_DUTY_LOW;
            r_cfg.duty_high      <= RST_DUTY_HIGH;
            r_cfg.step_limit     <= RST_STEP_LIMIT;
            r_cfg.step_filter_on <= RST_STEP_FILTER_ON;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pdc_front #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_channel     (i_channel),
        .i_edge_rising (i_edge_rising),
        .i_stamp       (i_stamp),
        .o_push        (w_push),
        .o_job         (w_front_job)
    );

    pdc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_job_pop),
        .o_job    (w_back_job),
        .o_status (w_q_status)
    );

    pdc_back #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_job          (w_back_job),
        .i_job_empty    (w_q_status.empty),
        .o_job_pop      (w_job_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_out_channel  (o_out_channel),
        .o_period_ticks (o_period_ticks),
        .o_high_ticks   (o_high_ticks),
        .o_duty         (o_duty),
        .o_held         (o_held)
    );

endmodule

[hw/rtl/pdc_front.sv]
// ----------------------------------------------------------------------------
// pdc_front
// per-channel edge tracking: captures rise and fall stamps and hands a
// finished period to the job queue
// ----------------------------------------------------------------------------
module pdc_front
    import pdc_pkg::*;
#(
    parameter int NUM_CHANNELS  = 4,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [CH_PORT_W-1:0] i_channel,
    input  logic                 i_edge_rising,
    input  logic [STAMP_W-1:0]   i_stamp,
    output logic                 o_push,
    output t_job                 o_job
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_phase                   r_phase [NUM_CHANNELS];
    logic [COUNTER_WIDTH-1:0] r_rise  [NUM_CHANNELS];
    logic [COUNTER_WIDTH-1:0] r_fall  [NUM_CHANNELS];

    t_phase                   n_phase;
    logic [CH_W-1:0]          w_idx;
    logic                     w_active;
    logic                     w_cap_rise;
    logic                     w_cap_fall;
    logic [COUNTER_WIDTH-1:0] w_stamp;
    logic [COUNTER_WIDTH-1:0] w_period;
    logic [COUNTER_WIDTH-1:0] w_hi;

    assign w_idx    = CH_W'(i_channel);
    assign w_active = i_accept && (int'(i_channel) < NUM_CHANNELS);
    assign w_stamp  = i_stamp[COUNTER_WIDTH-1:0];

    always_comb begin
        n_phase    = r_phase[w_idx];
        w_cap_rise = 1'b0;
        w_cap_fall = 1'b0;
        o_push     = 1'b0;
        case (r_phase[w_idx])
            PH_WAIT_FALL: begin
                if (!i_edge_rising) begin
                    w_cap_fall = w_active;
                    n_phase    = PH_WAIT_RISE2;
                end
            end
            PH_WAIT_RISE2: begin
                if (i_edge_rising) begin
                    o_push  = w_active;
                    n_phase = PH_WAIT_RISE;
                end
            end
            default: begin
                // the unused phase code behaves as waiting for a first rise
                if (i_edge_rising) begin
                    w_cap_rise = w_active;
                    n_phase    = PH_WAIT_FALL;
                end else begin
                    n_phase = PH_WAIT_RISE;
                end
            end
        endcase
    end

    // intervals wrap modulo the counter width
    assign w_period = w_stamp - r_rise[w_idx];
    assign w_hi     = r_fall[w_idx] - r_rise[w_idx];

    assign o_job.ch     = i_channel;
    assign o_job.period = STAMP_W'(w_period);
    assign o_job.hi     = STAMP_W'(w_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_phase[c] <= PH_WAIT_RISE;
            end
        end else if (w_active) begin
            r_phase[w_idx] <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cap_rise) begin
            r_rise[w_idx] <= w_stamp;
        end
        if (w_cap_fall) begin
            r_fall[w_idx] <= w_stamp;
        end
    end

    a_push_from_wait_rise2 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_phase[$past(w_idx)] == PH_WAIT_RISE))
        else $error("channel not re-armed after a completed period");

endmodule

[hw/rtl/pdc_queue.sv]
// ----------------------------------------------------------------------------
// pdc_queue
// short job fifo between the capture front and the divide back
// ----------------------------------------------------------------------------
module pdc_queue
    import pdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    logic [QUEUE_AW-1:0] n_wr_ptr;
    logic [QUEUE_AW-1:0] n_rd_ptr;
    logic [QUEUE_AW:0]   n_count;

    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_job          = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_wr_ptr + QUEUE_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_rd_ptr + QUEUE_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_push_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("job pushed into a full queue");

    a_no_pop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("job popped from an empty queue");

endmodule

[hw/rtl/pdc_back.sv]
// ----------------------------------------------------------------------------
// pdc_back
// duty computation: multiply, saturation check, restoring divide one
// quotient bit a cycle, window and step filter, result register
// ----------------------------------------------------------------------------
module pdc_back
    import pdc_pkg::*;
#(
    parameter int NUM_CHANNELS  = 4,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  t_job                 i_job,
    input  logic                 i_job_empty,
    output logic                 o_job_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [CH_PORT_W-1:0] o_out_channel,
    output logic [STAMP_W-1:0]   o_period_ticks,
    output logic [STAMP_W-1:0]   o_high_ticks,
    output logic [DUTY_W-1:0]    o_duty,
    output logic                 o_held
);

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int NUM_W = COUNTER_WIDTH + DUTY_W;
    localparam int BIT_W = $clog2(DUTY_W);

    t_bstate                  r_state;
    t_bstate                  n_state;

    logic [CH_PORT_W-1:0]     r_ch;
    logic [COUNTER_WIDTH-1:0] r_den;
    logic [COUNTER_WIDTH-1:0] r_hi;
    logic [NUM_W-1:0]         r_num;
    logic [NUM_W-1:0]         r_dsh;
    logic [DUTY_W-1:0]        r_quo;
    logic [BIT_W-1:0]         r_bit;
    logic                     r_sat;
    logic                     r_zero;
    logic [DUTY_W-1:0]        r_last [NUM_CHANNELS];

    logic                     r_out_valid;
    logic [CH_PORT_W-1:0]     r_out_ch;
    logic [STAMP_W-1:0]       r_out_period;
    logic [STAMP_W-1:0]       r_out_hi;
    logic [DUTY_W-1:0]        r_out_duty;
    logic                     r_out_held;

    logic                     w_slot_free;
    logic                     w_out_load;
    logic [CH_W-1:0]          w_idx;
    logic [DUTY_W-1:0]        w_duty;
    logic [DUTY_W-1:0]        w_last;
    logic [DUTY_W-1:0]        w_diff;
    logic                     w_held;

    assign w_slot_free = !r_out_valid || i_pop;
    assign w_idx       = CH_W'(r_ch);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    n_state = B_MUL;
                end
            end
            B_MUL:  n_state = B_SAT;
            B_SAT:  n_state = B_DIV;
            B_DIV: begin
                if (r_bit == '0) begin
                    n_state = B_FILT;
                end
            end
            B_FILT: begin
                if (w_slot_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_job_pop  = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            B_IDLE:  o_job_pop  = !i_job_empty;
            B_FILT:  w_out_load = w_slot_free;
            default: begin
                o_job_pop  = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (o_job_pop) begin
                    r_ch  <= i_job.ch;
                    r_den <= i_job.period[COUNTER_WIDTH-1:0];
                    r_hi  <= i_job.hi[COUNTER_WIDTH-1:0];
                end
            end
            B_MUL: begin
                r_num  <= NUM_W'(r_hi) * NUM_W'(FULL_SCALE);
                r_zero <= (r_den == '0);
            end
            B_SAT: begin
                // quotient of 2^14 or more saturates, so only 14 bits are developed
                r_sat <= (r_num >= (NUM_W'(r_den) << DUTY_W));
                r_dsh <= NUM_W'(r_den) << (DUTY_W - 1);
                r_quo <= '0;
                r_bit <= BIT_W'(DUTY_W - 1);
            end
            B_DIV: begin
                if (r_num >= r_dsh) begin
                    r_num        <= r_num - r_dsh;
                    r_quo[r_bit] <= 1'b1;
                end
                r_dsh <= r_dsh >> 1;
                r_bit <= r_bit - BIT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // window and step filter
    always_comb begin
        w_duty = r_sat ? DUTY_MAX : r_quo;
        w_last = r_last[w_idx];
        w_diff = (w_duty > w_last) ? (w_duty - w_last) : (w_last - w_duty);
        w_held = r_zero
              || (w_duty < i_cfg.duty_low)
              || (w_duty > i_cfg.duty_high)
              || (i_cfg.step_filter_on && (w_diff > i_cfg.step_limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_last[c] <= '0;
            end
        end else if (w_out_load && !w_held) begin
            r_last[w_idx] <= w_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ch     <= r_ch;
            r_out_period <= STAMP_W'(r_den);
            r_out_hi     <= STAMP_W'(r_hi);
            r_out_duty   <= w_held ? w_last : w_duty;
            r_out_held   <= w_held;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_channel  = r_out_ch;
    assign o_period_ticks = r_out_period;
    assign o_high_ticks   = r_out_hi;
    assign o_duty         = r_out_duty;
    assign o_held         = r_out_held;

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV && !r_sat) |-> ({1'b0, r_num} < ({1'b0, r_dsh} << 1)))
        else $error("divide remainder out of range");

    a_div_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MUL) |-> ##16 (r_state == B_FILT))
        else $error("divide did not finish in the expected cycle count");

endmodule
